/* src/assc_pkg.sv */
// Shared types and constants for the approximate substring score block.
// No dependencies; imported by every module of the block except assc_ram.
package assc_pkg;

	localparam int SCORE_W = 13;
	localparam logic [SCORE_W-1:0] SCORE_MAX = 13'd8191;

	localparam logic [1:0] ACT_TEXT  = 2'd0;
	localparam logic [1:0] ACT_QUERY = 2'd1;
	localparam logic [1:0] ACT_SCORE = 2'd2;

	localparam logic [1:0] REG_INSERT = 2'd0;
	localparam logic [1:0] REG_DELETE = 2'd1;
	localparam logic [1:0] REG_CHANGE = 2'd2;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] char_code;
	} req_t;

	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic               overflow;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_OUTER,
		ST_INNER,
		ST_WALK,
		ST_RD1,
		ST_EVAL,
		ST_MUL,
		ST_CMP,
		ST_DECIDE,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic append;
		logic init_score;
		logic init_outer;
		logic init_walk;
		logic rd0;
		logic rd1;
		logic eval;
		logic mul;
		logic cmp;
		logic decide;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic tlen_zero;
		logic s_end;
		logic b_end;
		logic walk_live;
		logic stop;
		logic out_free;
	} status_t;

endpackage

/* src/assc_ram.sv */
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module assc_ram #(
	parameter int W = 8,
	parameter int D = 64
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* src/assc_ctrl.sv */
// Sequencer for the scoring search: loads, outer/inner loops, walk steps.
// Depends on assc_pkg.
module assc_ctrl import assc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic [1:0] req_action,
	output logic       req_stall,
	input  status_t    st,
	output cmd_t       cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid && req_action == ACT_SCORE) state_d = ST_START;
			end
			ST_START:  state_d = st.tlen_zero ? ST_FIN : ST_OUTER;
			ST_OUTER:  state_d = st.s_end ? ST_FIN : ST_INNER;
			ST_INNER:  state_d = st.b_end ? ST_DECIDE : ST_WALK;
			ST_WALK:   state_d = st.walk_live ? ST_RD1 : ST_MUL;
			ST_RD1:    state_d = ST_EVAL;
			ST_EVAL:   state_d = st.stop ? ST_MUL : ST_WALK;
			ST_MUL:    state_d = ST_CMP;
			ST_CMP:    state_d = ST_INNER;
			ST_DECIDE: state_d = ST_OUTER;
			ST_FIN: begin
				if (st.out_free) state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		req_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				cmd.append = req_valid;
			end
			ST_START:  cmd.init_score = 1'b1;
			ST_OUTER:  cmd.init_outer = !st.s_end;
			ST_INNER:  cmd.init_walk = !st.b_end;
			ST_WALK:   cmd.rd0 = st.walk_live;
			ST_RD1:    cmd.rd1 = 1'b1;
			ST_EVAL:   cmd.eval = 1'b1;
			ST_MUL:    cmd.mul = 1'b1;
			ST_CMP:    cmd.cmp = 1'b1;
			ST_DECIDE: cmd.decide = 1'b1;
			ST_FIN:    cmd.load_out = st.out_free;
			default:   cmd = '0;
		endcase
	end

endmodule

/* src/assc_dp.sv */
// Datapath: string stores, cost registers, walk/score arithmetic, result register.
// Depends on assc_pkg and assc_ram.
module assc_dp import assc_pkg::*; #(
	parameter int MAX_TEXT = 64,
	parameter int MAX_QUERY = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  req_t       req,
	input  logic       wr_en,
	input  logic [1:0] wr_index,
	input  logic [3:0] wr_data,
	input  cmd_t       cmd,
	output status_t    st,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output rsp_t       rsp
);

	localparam int MAXL = (MAX_TEXT > MAX_QUERY) ? MAX_TEXT : MAX_QUERY;
	localparam int IW   = $clog2(MAXL + 3);
	localparam int TAW  = $clog2(MAX_TEXT);
	localparam int QAW  = $clog2(MAX_QUERY);
	localparam int PW   = IW + 5;
	localparam int SW   = 2 * IW + 2;
	localparam int TW   = (2 * IW + 3 > SCORE_W + 2) ? 2 * IW + 3 : SCORE_W + 2;

	logic [3:0] ic_q, dc_q, cc_q;
	logic [IW-1:0] tlen_q, qlen_q, wb_q, ws_q, b_q, s_q, best_end_q, hits_q;
	logic [PW-1:0] pen_q;
	logic [2*IW-1:0] sq_q;
	logic signed [SW-1:0] best_q;
	logic signed [TW-1:0] total_q;
	logic have_q, ovf_q, tv_q, qv_q, rsp_valid_q;
	logic [7:0] t0_q, q0_q;
	rsp_t rsp_q;

	logic [7:0] t_rdata, q_rdata, t1, q1;
	logic t_we, q_we;
	logic [IW-1:0] t_ridx, q_ridx;
	logic m0, m1, m2, m3;
	logic signed [SW-1:0] sc;
	logic signed [TW-1:0] dc_m1;

	// appends
	assign t_we = cmd.append && req.action == ACT_TEXT && req.char_code != 8'd0
		&& tlen_q < IW'(MAX_TEXT);
	assign q_we = cmd.append && req.action == ACT_QUERY && req.char_code != 8'd0
		&& qlen_q < IW'(MAX_QUERY);

	assign t_ridx = cmd.rd0 ? wb_q : wb_q + IW'(1);
	assign q_ridx = cmd.rd0 ? ws_q : ws_q + IW'(1);

	assc_ram #(.W(8), .D(MAX_TEXT)) u_text (
		.clk(clk), .we(t_we), .waddr(tlen_q[TAW-1:0]), .wdata(req.char_code),
		.raddr(t_ridx[TAW-1:0]), .rdata(t_rdata)
	);

	assc_ram #(.W(8), .D(MAX_QUERY)) u_query (
		.clk(clk), .we(q_we), .waddr(qlen_q[QAW-1:0]), .wdata(req.char_code),
		.raddr(q_ridx[QAW-1:0]), .rdata(q_rdata)
	);

	// positions past an end read as zero
	assign t1 = tv_q ? t_rdata : 8'd0;
	assign q1 = qv_q ? q_rdata : 8'd0;
	assign m0 = t0_q == q0_q;
	assign m1 = t1 == q0_q;
	assign m2 = t0_q == q1;
	assign m3 = t1 == q1;

	assign sc = $signed(SW'(sq_q)) - $signed(SW'(pen_q));
	assign dc_m1 = $signed(TW'(dc_q)) - $signed(TW'(1));

	assign st.tlen_zero = tlen_q == '0;
	assign st.s_end     = s_q >= qlen_q;
	assign st.b_end     = b_q >= tlen_q;
	assign st.walk_live = wb_q < tlen_q && ws_q < qlen_q;
	assign st.stop      = !(m0 || m1 || m2 || m3);
	assign st.out_free  = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ic_q <= 4'd1;
			dc_q <= 4'd1;
			cc_q <= 4'd3;
			tlen_q <= '0;
			qlen_q <= '0;
			ovf_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				unique case (wr_index)
					REG_INSERT: ic_q <= wr_data;
					REG_DELETE: dc_q <= wr_data;
					REG_CHANGE: cc_q <= wr_data;
					default: ;
				endcase
			end
			if (t_we) tlen_q <= tlen_q + IW'(1);
			if (q_we) qlen_q <= qlen_q + IW'(1);
			if (cmd.append && req.char_code != 8'd0 &&
				((req.action == ACT_TEXT && !t_we) || (req.action == ACT_QUERY && !q_we)))
				ovf_q <= 1'b1;
			rsp_valid_q <= cmd.load_out || (rsp_valid_q && rsp_stall);
			if (cmd.load_out) begin
				tlen_q <= '0;
				qlen_q <= '0;
				ovf_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init_score) begin
			total_q <= '0;
			s_q <= '0;
		end
		if (cmd.init_outer) begin
			best_q <= '1;
			have_q <= 1'b0;
			b_q <= '0;
		end
		if (cmd.init_walk) begin
			wb_q <= b_q;
			ws_q <= s_q;
			hits_q <= '0;
			pen_q <= '0;
		end
		if (cmd.rd0) begin
			tv_q <= wb_q < tlen_q;
			qv_q <= ws_q < qlen_q;
		end
		if (cmd.rd1) begin
			t0_q <= tv_q ? t_rdata : 8'd0;
			q0_q <= qv_q ? q_rdata : 8'd0;
			tv_q <= (wb_q + IW'(1)) < tlen_q;
			qv_q <= (ws_q + IW'(1)) < qlen_q;
		end
		if (cmd.eval && !st.stop) begin
			hits_q <= hits_q + IW'(1);
			if (m0) begin
				wb_q <= wb_q + IW'(1);
				ws_q <= ws_q + IW'(1);
			end else if (m1) begin
				wb_q <= wb_q + IW'(2);
				ws_q <= ws_q + IW'(1);
				pen_q <= pen_q + PW'(ic_q);
			end else if (m2) begin
				wb_q <= wb_q + IW'(1);
				ws_q <= ws_q + IW'(2);
				pen_q <= pen_q + PW'(dc_q);
			end else begin
				wb_q <= wb_q + IW'(2);
				ws_q <= ws_q + IW'(2);
				pen_q <= pen_q + PW'(cc_q);
			end
		end
		if (cmd.mul) sq_q <= (2 * IW)'(hits_q) * (2 * IW)'(hits_q);
		if (cmd.cmp) begin
			// strict compare: first of equal scores stays
			if (sc > best_q) begin
				best_q <= sc;
				best_end_q <= ws_q;
				have_q <= 1'b1;
			end
			b_q <= b_q + IW'(1);
		end
		if (cmd.decide) begin
			if (have_q && best_end_q > s_q) begin
				total_q <= total_q + TW'(best_q);
				s_q <= best_end_q;
			end else begin
				if (total_q >= dc_m1) total_q <= total_q - $signed(TW'(dc_q));
				s_q <= s_q + IW'(1);
			end
		end
		if (cmd.load_out) begin
			rsp_q.overflow <= ovf_q;
			if (total_q < 0) rsp_q.score <= '0;
			else if (total_q > $signed(TW'(SCORE_MAX))) rsp_q.score <= SCORE_MAX;
			else rsp_q.score <= total_q[SCORE_W-1:0];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

/* src/approximate_substring_score_top.sv */
// Top level of the approximate substring score block.
// Depends on assc_pkg, assc_ctrl, assc_dp (and assc_ram below it).
//
//  word    | valid     | stall     | payload
//  request | req_valid | req_stall | req (action, char_code)
//  result  | rsp_valid | rsp_stall | rsp (score, overflow)
//  config  | wr_en     | -         | wr_index, wr_data
//
// Character words are taken at once while idle. A score word is taken at once, then the
// request side stalls through the search (walk steps of read, second read, compare, plus
// text start and query position states), bounded by the stored lengths.
// Reset clears lengths, overflow flag and result valid, and restores the default costs.
// A result held by rsp_stall blocks only the next score word's completion.
module approximate_substring_score_top import assc_pkg::*; #(
	parameter int MAX_TEXT = 64,
	parameter int MAX_QUERY = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  req_t       req,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output rsp_t       rsp,
	input  logic       wr_en,
	input  logic [1:0] wr_index,
	input  logic [3:0] wr_data
);

	cmd_t    cmd;
	status_t st;

	assc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_action(req.action),
		.req_stall(req_stall), .st(st), .cmd(cmd)
	);

	assc_dp #(.MAX_TEXT(MAX_TEXT), .MAX_QUERY(MAX_QUERY)) u_dp (
		.clk(clk), .arst_n(arst_n), .req(req), .wr_en(wr_en), .wr_index(wr_index),
		.wr_data(wr_data), .cmd(cmd), .st(st), .rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall), .rsp(rsp)
	);

endmodule
